// File: design/cprgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprgb_pkg
// Shared types and constants for the camera byte to RGB888 converter.
// ----------------------------------------------------------------------------
package cprgb_pkg;

	localparam int DIM_W = 13;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_INPUT_FORMAT = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHANNEL_SWAP = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

	localparam logic [1:0] FMT_RAW    = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_MONO   = 2'd2;

	localparam logic [1:0] SWAP_NONE = 2'd0;
	localparam logic [1:0] SWAP_RB   = 2'd1;
	localparam logic [1:0] SWAP_RG   = 2'd2;
	localparam logic [1:0] SWAP_GB   = 2'd3;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// per-word control carried alongside the pixel byte
	typedef struct packed {
		logic raw;
		logic rgb565;
		logic second_byte;
		logic emit;
		logic last_col;
		logic last_row;
		logic odd_row;
		logic odd_col;
	} pos_t;

endpackage

// File: design/cprgb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprgb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cprgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/cprgb_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprgb_position
// Column, line and byte-phase tracking; decides which words give a pixel.
// ----------------------------------------------------------------------------
module cprgb_position
	import cprgb_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         sof,
	input  logic [1:0]                   fmt,
	input  logic [DIM_W-1:0]             frame_width,
	input  logic [DIM_W-1:0]             frame_height,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output pos_t                         pos
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [COL_W-1:0] col_q, col_cur, w_m1;
	logic [ROW_W-1:0] row_q, row_cur, h_m1;
	logic             phase_q, phase_cur;
	logic [31:0]      fw32, fh32;
	logic             is_raw, is_565, advance, last_col, last_row;

	assign fw32 = 32'(frame_width);
	assign fh32 = 32'(frame_height);

	always_comb begin
		if (fw32 < 32'd2) begin
			w_m1 = COL_W'(1);
		end else if (fw32 > 32'(MAX_WIDTH)) begin
			w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_W'(fw32 - 32'd1);
		end
		if (fh32 < 32'd2) begin
			h_m1 = ROW_W'(1);
		end else if (fh32 > 32'(MAX_HEIGHT)) begin
			h_m1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = ROW_W'(fh32 - 32'd1);
		end
	end

	assign col_cur   = sof ? '0 : col_q;
	assign row_cur   = sof ? '0 : row_q;
	assign phase_cur = sof ? 1'b0 : phase_q;
	assign last_col  = col_cur >= w_m1;
	assign last_row  = row_cur >= h_m1;
	assign is_raw    = fmt == FMT_RAW;
	assign is_565    = fmt == FMT_RGB565;
	assign advance   = !(is_565 && !phase_cur);

	always_comb begin
		pos.raw         = is_raw;
		pos.rgb565      = is_565;
		pos.second_byte = phase_cur;
		pos.last_col    = last_col;
		pos.last_row    = last_row;
		pos.odd_row     = !row_cur[0];
		pos.odd_col     = !col_cur[0];
		if (is_raw) begin
			pos.emit = (col_cur != '0) && (row_cur != '0);
		end else if (is_565) begin
			pos.emit = phase_cur;
		end else begin
			pos.emit = 1'b1;
		end
	end

	assign col = col_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			phase_q <= is_565 ? !phase_cur : 1'b0;
			if (!advance) begin
				col_q <= col_cur;
				row_q <= row_cur;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_cur + ROW_W'(1);
			end else begin
				col_q <= col_cur + COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

endmodule

// File: design/cprgb_colour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprgb_colour
// Window registers and colour reconstruction for raw, RGB565 and mono words.
// ----------------------------------------------------------------------------
module cprgb_colour
	import cprgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  pos_t        pos,
	input  logic [7:0]  px,
	input  logic [7:0]  top_right,
	input  logic [1:0]  swap,
	output logic [23:0] rgb
);

	logic [7:0] left_q, upper_q, hold_q;
	logic [7:0] r, g, b, ro, go, bo;
	logic [5:0] g6;

	assign g6 = {hold_q[2:0], px[7:5]};

	always_comb begin
		if (pos.raw) begin
			case ({pos.odd_row, pos.odd_col})
				2'b00: begin
					r = upper_q;
					g = (top_right >> 1) + (left_q >> 1);
					b = px;
				end
				2'b01: begin
					r = top_right;
					g = (upper_q >> 1) + (px >> 1);
					b = left_q;
				end
				2'b10: begin
					r = left_q;
					g = (upper_q >> 1) + (px >> 1);
					b = top_right;
				end
				default: begin
					r = px;
					g = (top_right >> 1) + (left_q >> 1);
					b = upper_q;
				end
			endcase
		end else if (pos.rgb565) begin
			r = {hold_q[7:3], 3'b000};
			g = {g6, 2'b00};
			b = {px[4:0], 3'b000};
		end else begin
			r = px;
			g = px;
			b = px;
		end
	end

	always_comb begin
		ro = r;
		go = g;
		bo = b;
		case (swap)
			SWAP_RB: begin
				ro = b;
				bo = r;
			end
			SWAP_RG: begin
				ro = g;
				go = r;
			end
			SWAP_GB: begin
				go = b;
				bo = g;
			end
			default: ;
		endcase
	end

	assign rgb = {bo, go, ro};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			upper_q <= '0;
			hold_q  <= '0;
		end else if (fire) begin
			if (pos.raw) begin
				upper_q <= top_right;
				left_q  <= px;
			end
			if (pos.rgb565 && !pos.second_byte) begin
				hold_q <= px;
			end
		end
	end

endmodule

// File: design/camera_pixel_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_pixel_to_rgb_converter
// Camera byte stream to RGB888: RGGB 2x2 demosaic, RGB565 unpack or mono.
//
//   channel | dir | tdata / data                    | tuser / index  | tlast
//   s_      | in  | [7:0] pixel_byte                | start_of_frame | -
//   m_      | out | [7:0] red [15:8] green [23:16]  | end_of_frame   | end_of_line
//           |     | blue                            |                |
//   cfg_    | in  | [12:0] register value           | [1:0] index    | -
//
// One word per clock while m_ does not stall; an accepted word is registered in s1, then its pixel on m_.
// The line buffer read is issued on accept and its registered data is used while the word sits in s1.
// Reset clears counters, window registers and config; line buffer is not cleared.
// A stalled m_ holds the pixel; the input stage still takes one more word.
// ----------------------------------------------------------------------------
module camera_pixel_to_rgb_converter
	import cprgb_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] pixel_byte
	input  logic             s_tuser,   // [0] start_of_frame
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	output logic             m_tlast,
	output logic             m_tuser,   // [0] end_of_frame
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [1:0]       fmt_q, swap_q;
	logic [DIM_W-1:0] width_q, height_q;

	logic             accept, fire, room;
	logic [COL_W-1:0] col_next;
	pos_t             pos_next;

	logic             valid_s1, byp_s1;
	pos_t             pos_s1;
	logic [COL_W-1:0] col_s1;
	logic [7:0]       px_s1, fwd_s1;
	logic [7:0]       ram_q, top_right;
	logic [23:0]      rgb;

	logic             m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [23:0]      m_tdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RAW;
			swap_q   <= SWAP_NONE;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INPUT_FORMAT: fmt_q    <= cfg_data[1:0];
				REG_CHANNEL_SWAP: swap_q   <= cfg_data[1:0];
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign room     = !m_tvalid_q || m_tready;
	assign fire     = valid_s1 && (!pos_s1.emit || room);
	assign s_tready = !valid_s1 || fire;
	assign accept   = s_tvalid && s_tready;

	cprgb_position #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sof         (s_tuser),
		.fmt         (fmt_q),
		.frame_width (width_q),
		.frame_height(height_q),
		.col         (col_next),
		.pos         (pos_next)
	);

	cprgb_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (fire && pos_s1.raw),
		.waddr(col_s1),
		.wdata(px_s1),
		.re   (accept),
		.raddr(col_next),
		.rdata(ram_q)
	);

	// word in s1 writes the same column as the incoming read: forward it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= s_tdata;
			pos_s1 <= pos_next;
			col_s1 <= col_next;
			byp_s1 <= valid_s1 && pos_s1.raw && (col_s1 == col_next);
			fwd_s1 <= px_s1;
		end
	end

	assign top_right = byp_s1 ? fwd_s1 : ram_q;

	cprgb_colour u_colour (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.pos      (pos_s1),
		.px       (px_s1),
		.top_right(top_right),
		.swap     (swap_q),
		.rgb      (rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire && pos_s1.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pos_s1.emit) begin
			m_tdata_q <= rgb;
			m_tlast_q <= pos_s1.last_col;
			m_tuser_q <= pos_s1.last_col && pos_s1.last_row;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word lost before s1");

	a_eof_is_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("end of frame without end of line");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(fire && pos_s1.emit))
		else $error("pending pixel overwritten");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the camera byte to RGB888 converter. Camera words
// are streamed in under raw Bayer, RGB565 and mono settings with every
// channel swap. Frame sizes run from the clamped minimum up to the widest
// line, with wrap, mid-line shrink and format changes between frames.
// A behavioural model in the scoreboard predicts each pixel and its line
// and frame flags. Each pixel taken from the output is compared with the
// oldest prediction. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
	import cprgb_pkg::*;

	localparam int MAX_DIM     = 4096;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_GAP   = 8;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       end_of_line;
		logic       end_of_frame;
	} pixel_t;

	class pixel_scoreboard;
		logic [1:0]       fmt;
		logic [1:0]       swap;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		logic [7:0]       line_mem [0:MAX_DIM-1];
		bit               line_written [0:MAX_DIM-1];
		logic [7:0]       left_px;
		logic [7:0]       upper_left_px;
		logic [7:0]       hold_byte;
		bit               second_byte;
		int unsigned      col;
		int unsigned      row;
		pixel_t           pixel_q [$];
		int               errors;
		int               checked;
		int               words;

		function new();
			fmt = FMT_RAW;
			swap = SWAP_NONE;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (line_written[i]) line_written[i] = 1'b0;
			left_px = '0;
			upper_left_px = '0;
			hold_byte = '0;
			second_byte = 1'b0;
			col = 0;
			row = 0;
			errors = 0;
			checked = 0;
			words = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
			case (idx)
				REG_INPUT_FORMAT: fmt = val[1:0];
				REG_CHANNEL_SWAP: swap = val[1:0];
				REG_FRAME_WIDTH:  width_reg = val;
				REG_FRAME_HEIGHT: height_reg = val;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_dim(logic [DIM_W-1:0] v);
			if (v < 2) return 2;
			if (v > MAX_DIM) return MAX_DIM;
			return v;
		endfunction

		function int unsigned frame_words();
			return clamp_dim(width_reg) * clamp_dim(height_reg) *
				((fmt == FMT_RGB565) ? 2 : 1);
		endfunction

		// next raw word would pull a never-written line entry into a pixel
		function bit line_hole();
			return fmt == FMT_RAW && row >= 1 && !line_written[col];
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction

		function void queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
				bit eol, bit eof);
			pixel_t p;
			case (swap)
				SWAP_RB: {r, b} = {b, r};
				SWAP_RG: {r, g} = {g, r};
				SWAP_GB: {g, b} = {b, g};
				default: ;
			endcase
			p.red = r;
			p.green = g;
			p.blue = b;
			p.end_of_line = eol;
			p.end_of_frame = eof;
			pixel_q.push_back(p);
		endfunction

		function void note_input(logic [7:0] px, logic sof);
			int unsigned w;
			int unsigned h;
			bit          last_col;
			bit          last_row;
			bit          advance;
			logic [7:0]  tl;
			logic [7:0]  tr;
			logic [7:0]  bl;
			logic [5:0]  g6;
			words++;
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			advance = 1'b1;
			if (sof) begin
				col = 0;
				row = 0;
				second_byte = 1'b0;
			end
			last_col = col >= w - 1;
			last_row = row >= h - 1;
			case (fmt)
				FMT_RAW: begin
					tr = line_mem[col];
					tl = upper_left_px;
					bl = left_px;
					second_byte = 1'b0;
					if (col >= 1 && row >= 1) begin
						case ({((row - 1) & 1) != 0, ((col - 1) & 1) != 0})
							2'b00: queue_pixel(tl, (tr >> 1) + (bl >> 1), px,
								last_col, last_col && last_row);
							2'b01: queue_pixel(tr, (tl >> 1) + (px >> 1), bl,
								last_col, last_col && last_row);
							2'b10: queue_pixel(bl, (tl >> 1) + (px >> 1), tr,
								last_col, last_col && last_row);
							default: queue_pixel(px, (tr >> 1) + (bl >> 1), tl,
								last_col, last_col && last_row);
						endcase
					end
					upper_left_px = tr;
					line_mem[col] = px;
					line_written[col] = 1'b1;
					left_px = px;
				end
				FMT_RGB565: begin
					if (!second_byte) begin
						hold_byte = px;
						second_byte = 1'b1;
						advance = 1'b0;
					end else begin
						g6 = {hold_byte[2:0], px[7:5]};
						queue_pixel({hold_byte[7:3], 3'b000}, {g6, 2'b00},
							{px[4:0], 3'b000}, last_col, last_col && last_row);
						second_byte = 1'b0;
					end
				end
				default: begin
					// mono, and the spare format code too
					second_byte = 1'b0;
					queue_pixel(px, px, px, last_col, last_col && last_row);
				end
			endcase
			if (advance) begin
				if (last_col) begin
					col = 0;
					row = last_row ? 0 : row + 1;
				end else begin
					col++;
				end
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50) $display("ERROR: %s", msg);
		endtask

		task check_result(pixel_t got);
			pixel_t exp_px;
			checked++;
			if (pixel_q.size() == 0) begin
				report($sformatf("pixel %0d unexpected: r %02h g %02h b %02h",
					checked, got.red, got.green, got.blue));
			end else begin
				exp_px = pixel_q.pop_front();
				if (got.red !== exp_px.red || got.green !== exp_px.green ||
						got.blue !== exp_px.blue || got.end_of_line !== exp_px.end_of_line ||
						got.end_of_frame !== exp_px.end_of_frame) begin
					report($sformatf("pixel %0d: got %02h %02h %02h %b%b, want %02h %02h %02h %b%b",
						checked, got.red, got.green, got.blue, got.end_of_line,
						got.end_of_frame, exp_px.red, exp_px.green, exp_px.blue,
						exp_px.end_of_line, exp_px.end_of_frame));
				end
			end
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;     // [7:0] pixel_byte
	logic             s_tuser = 1'b0;   // [0] start_of_frame
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;          // [7:0] red, [15:8] green, [23:16] blue
	logic             m_tlast;
	logic             m_tuser;          // [0] end_of_frame
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	int send_idle = 11;
	int recv_idle = 62;
	int cfg_writes = 0;
	int settings = 0;
	int rand_words = 0;

	camera_pixel_to_rgb_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// output side: take pixels, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast, m_tuser});
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Timeout: no word moved for %0d cycles, %0d pixels outstanding",
			STALL_LIMIT, sb.pending());
		$display("Mismatches found");
		$finish;
	end

	task automatic drive_word(logic [7:0] b, logic sof);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
		sb.note_input(b, sof);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic configure(logic [DIM_W-1:0] fmt_v, logic [DIM_W-1:0] swap_v,
			logic [DIM_W-1:0] w_v, logic [DIM_W-1:0] h_v, logic [3:0] which);
		drain();
		if (which[0]) write_reg(REG_INPUT_FORMAT, fmt_v);
		if (which[1]) write_reg(REG_CHANNEL_SWAP, swap_v);
		if (which[2]) write_reg(REG_FRAME_WIDTH, w_v);
		if (which[3]) write_reg(REG_FRAME_HEIGHT, h_v);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// raster frames with random content, the odd stray or missing frame start
	task automatic send_frames(int n, bit lead_sof, int hold_at);
		int  frame_len;
		bit  sof;
		frame_len = sb.frame_words();
		for (int i = 0; i < n; i++) begin
			if (i == hold_at) drain();
			sof = 1'b0;
			if (i == 0)
				sof = lead_sof;
			else if (i % frame_len == 0 && $urandom_range(9) != 0)
				sof = 1'b1;
			if ($urandom_range(99) < 2) sof = 1'b1;
			if (sb.line_hole()) sof = 1'b1;
			drive_word(8'($urandom_range(255)), sof);
		end
	endtask

	function automatic logic [DIM_W-1:0] code_value(int code);
		// upper register bits are ignored; set them now and then
		if ($urandom_range(3) == 0)
			return DIM_W'(code) | DIM_W'($urandom_range(2047) << 2);
		return DIM_W'(code);
	endfunction

	initial begin : main
		logic [7:0]       raw_words [16];
		logic [7:0]       pair_words [8];
		logic [DIM_W-1:0] w_v;
		logic [DIM_W-1:0] h_v;
		int               fl;
		int               n;
		int               pick;
		bit               first;
		raw_words = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFF, 8'h00};
		pair_words = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hF8, 8'h00, 8'h07, 8'hE0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4x4 raw frame: all four colour phases, line and frame ends
		configure(DIM_W'(FMT_RAW), DIM_W'(SWAP_NONE), 4, 4, 4'hF);
		foreach (raw_words[i]) drive_word(raw_words[i], i == 0);
		// 2x2 RGB565: full scale, zero, red field alone and green field alone
		configure(DIM_W'(FMT_RGB565), DIM_W'(SWAP_RB), 2, 2, 4'hF);
		foreach (pair_words[i]) drive_word(pair_words[i], i == 0);

		first = 1'b1;
		while (rand_words < 1100) begin
			if (rand_words < 370) begin
				send_idle = 11;
				recv_idle = 62;
			end else if (rand_words < 740) begin
				send_idle = 62;
				recv_idle = 11;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			pick = $urandom_range(99);
			w_v = (pick < 80) ? DIM_W'($urandom_range(2, 10)) :
				(pick < 90) ? DIM_W'($urandom_range(0, 1)) : DIM_W'($urandom_range(11, 8191));
			pick = $urandom_range(99);
			h_v = (pick < 85) ? DIM_W'($urandom_range(2, 6)) :
				(pick < 93) ? DIM_W'($urandom_range(0, 1)) : DIM_W'($urandom_range(7, 8191));
			configure(code_value($urandom_range(3)), code_value($urandom_range(3)), w_v, h_v,
				first ? 4'hF : 4'($urandom_range(1, 15)));
			fl = sb.frame_words();
			n = fl * $urandom_range(1, 3);
			if ($urandom_range(3) == 0) n += $urandom_range(0, fl);
			if (n > 300) n = 300;
			if (n < 4) n = 4;
			send_frames(n, $urandom_range(9) != 0,
				(first || $urandom_range(3) == 0) ? $urandom_range(1, n - 1) : -1);
			rand_words += n;
			first = 1'b0;
		end

		// widest line setting, start of a frame; then the tallest frame with the spare format code (mono)
		configure(DIM_W'(FMT_RAW), DIM_W'(SWAP_GB), 8191, 2, 4'hF);
		send_frames(200, 1'b1, -1);
		configure(3, DIM_W'(SWAP_RG), 4, 4096, 4'hF);
		send_frames(100, 1'b1, -1);

		drain();
		repeat (4 * DRAIN_GAP) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d predicted pixels never arrived", sb.pending()));
		$display("Covered %0d camera words over %0d settings (%0d register writes): raw, RGB565,",
			sb.words, settings, cfg_writes);
		$display("mono and spare format, all swaps, sizes clamped 2..4096; %0d pixels compared",
			sb.checked);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
